// ===== rtl/csi_pkg.sv =====
// csi_pkg: shared constants for the circle/segment intersection unit.
// No dependencies.
package csi_pkg;

    // Stage count of the pipeline (start to done).
    localparam int unsigned PIPE_STAGES = 6;

endpackage

// ===== rtl/circle_segment_intersect_unit.sv =====
// circle_segment_intersect_unit: exact circle / line-segment hit test.
// Depends on csi_pkg.
//
// Each word gives a circle (center, radius) and a segment (start, end) in
// signed Q8.16 fixed point. The unit reports hit = 1 when the segment touches
// or crosses the circle: some point end + t*(start - end) with 0 <= t <= 1
// lies exactly on the circle. The test is exact integer math, with no
// division, no square root and no rounding. A zero-length segment gives 0,
// and so does a segment that lies wholly inside the circle.
// Timing: busy is tied low, so a word is taken in every cycle that start is
// high. Its result shows on hit with done high after the register stages
// below (csi_pkg::PIPE_STAGES) and stays for one cycle only. The receiver
// cannot stall the unit, so results follow each other at one per cycle in
// the order the words were taken. The six register stages are: coordinate
// differences; products (one multiplier each); sums and signs of the end
// values, dot products and cross product; partial products of the squared
// cross product and of |d|^2 * r^2 (each operand split in halves, so no
// multiplier is wider than about half the operand); the two partial sums;
// then the final compare.
module circle_segment_intersect_unit #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic        [COORD_WIDTH-2:0] radius,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    output logic                          done,
    output logic                          hit
);

    // Difference width, product width and sum-of-products width.
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int RW = 2 * (COORD_WIDTH - 1);
    localparam int QW = 2 * SW;
    // Split points for the wide products: low and high halves.
    localparam int LO = SW / 2;
    localparam int LH = SW - LO;
    localparam int RL = RW / 2;
    localparam int RH = RW - RL;

    // Stage 1: differences.
    logic [csi_pkg::PIPE_STAGES-1:0] vld_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, wx_reg, wy_reg, ux_reg, uy_reg;
    logic [COORD_WIDTH-2:0] rad_reg;

    // Stage 2: products.
    logic signed [PW-1:0] dxx_reg, dyy_reg, wxx_reg, wyy_reg, uxx_reg, uyy_reg;
    logic signed [PW-1:0] dwx_reg, dwy_reg, dux_reg, duy_reg, cr1_reg, cr2_reg;
    logic [RW-1:0]        rr_reg;

    // Stage 3: sums and early decision.
    logic [SW-1:0]        lensq_reg;
    logic [RW-1:0]        rr3_reg;
    logic signed [SW-1:0] crs_reg;
    logic                 pre_hit_reg, pre_miss_reg;

    // Stage 4: partial products.
    logic signed [2*LH-1:0] sq_hh_reg;
    logic signed [LH+LO:0]  sq_hl_reg;
    logic [2*LO-1:0]        sq_ll_reg;
    logic [LH+RH-1:0]       pr_hh_reg;
    logic [LH+RL-1:0]       pr_hl_reg;
    logic [LO+RH-1:0]       pr_lh_reg;
    logic [LO+RL-1:0]       pr_ll_reg;
    logic                   pre_hit4_reg, pre_miss4_reg;

    // Stage 5: squared cross product and |d|^2 * r^2.
    logic [QW-1:0]        lhs_reg, rhs_reg;
    logic                 pre_hit5_reg, pre_miss5_reg;

    // Stage 6: final compare.
    logic                 hit_reg;

    logic signed [SW-1:0] at0_next, at1_next, lin_next, ahead_next;
    logic [QW-1:0]        lhs_next, rhs_next;
    logic                 miss_next, sure_next;
    logic signed [LH-1:0] crs_hi;
    logic [LO-1:0]        crs_lo;

    assign busy = 1'b0;

    assign crs_hi = crs_reg[SW-1:LO];
    assign crs_lo = crs_reg[LO-1:0];

    always_comb
    begin
        at0_next   = SW'(wxx_reg) + SW'(wyy_reg) - SW'(rr_reg);
        at1_next   = SW'(uxx_reg) + SW'(uyy_reg) - SW'(rr_reg);
        lin_next   = SW'(dwx_reg) + SW'(dwy_reg);
        ahead_next = SW'(dux_reg) + SW'(duy_reg);
        // Zero length, both ends inside, or vertex outside (0,1): miss.
        miss_next  = ((dxx_reg == '0) && (dyy_reg == '0))
                   || (at0_next < 0 && at1_next < 0)
                   || (!(at0_next <= 0 || at1_next <= 0)
                       && (lin_next >= 0 || ahead_next <= 0));
        // An end on or inside the circle with the other not inside: hit.
        sure_next  = (at0_next <= 0 || at1_next <= 0);
        // Recombine the halves: crs^2 = hi^2 << 2LO + 2*hi*lo << LO + lo^2.
        lhs_next   = (QW'(sq_hh_reg) << (2 * LO)) + (QW'(sq_hl_reg) << (LO + 1))
                   + QW'(sq_ll_reg);
        rhs_next   = (QW'(pr_hh_reg) << (LO + RL)) + (QW'(pr_hl_reg) << LO)
                   + (QW'(pr_lh_reg) << RL) + QW'(pr_ll_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[csi_pkg::PIPE_STAGES-2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        // Stage 1
        dx_reg  <= DW'(start_x) - DW'(end_x);
        dy_reg  <= DW'(start_y) - DW'(end_y);
        wx_reg  <= DW'(end_x) - DW'(center_x);
        wy_reg  <= DW'(end_y) - DW'(center_y);
        ux_reg  <= DW'(start_x) - DW'(center_x);
        uy_reg  <= DW'(start_y) - DW'(center_y);
        rad_reg <= radius;
        // Stage 2
        dxx_reg <= PW'(dx_reg) * PW'(dx_reg);
        dyy_reg <= PW'(dy_reg) * PW'(dy_reg);
        wxx_reg <= PW'(wx_reg) * PW'(wx_reg);
        wyy_reg <= PW'(wy_reg) * PW'(wy_reg);
        uxx_reg <= PW'(ux_reg) * PW'(ux_reg);
        uyy_reg <= PW'(uy_reg) * PW'(uy_reg);
        dwx_reg <= PW'(dx_reg) * PW'(wx_reg);
        dwy_reg <= PW'(dy_reg) * PW'(wy_reg);
        dux_reg <= PW'(dx_reg) * PW'(ux_reg);
        duy_reg <= PW'(dy_reg) * PW'(uy_reg);
        cr1_reg <= PW'(dx_reg) * PW'(wy_reg);
        cr2_reg <= PW'(dy_reg) * PW'(wx_reg);
        rr_reg  <= RW'(rad_reg) * RW'(rad_reg);
        // Stage 3
        lensq_reg    <= SW'($unsigned(dxx_reg)) + SW'($unsigned(dyy_reg));
        rr3_reg      <= rr_reg;
        crs_reg      <= SW'(cr1_reg) - SW'(cr2_reg);
        pre_miss_reg <= miss_next;
        pre_hit_reg  <= sure_next;
        // Stage 4
        sq_hh_reg     <= (2*LH)'(crs_hi) * (2*LH)'(crs_hi);
        sq_hl_reg     <= (LH+LO+1)'(crs_hi) * (LH+LO+1)'($signed({1'b0, crs_lo}));
        sq_ll_reg     <= (2*LO)'(crs_lo) * (2*LO)'(crs_lo);
        pr_hh_reg     <= (LH+RH)'(lensq_reg[SW-1:LO]) * (LH+RH)'(rr3_reg[RW-1:RL]);
        pr_hl_reg     <= (LH+RL)'(lensq_reg[SW-1:LO]) * (LH+RL)'(rr3_reg[RL-1:0]);
        pr_lh_reg     <= (LO+RH)'(lensq_reg[LO-1:0]) * (LO+RH)'(rr3_reg[RW-1:RL]);
        pr_ll_reg     <= (LO+RL)'(lensq_reg[LO-1:0]) * (LO+RL)'(rr3_reg[RL-1:0]);
        pre_miss4_reg <= pre_miss_reg;
        pre_hit4_reg  <= pre_hit_reg;
        // Stage 5
        lhs_reg       <= lhs_next;
        rhs_reg       <= rhs_next;
        pre_miss5_reg <= pre_miss4_reg;
        pre_hit5_reg  <= pre_hit4_reg;
        // Stage 6
        hit_reg <= !pre_miss5_reg && (pre_hit5_reg || rhs_reg >= lhs_reg);
    end

    assign done = vld_reg[csi_pkg::PIPE_STAGES-1];
    assign hit  = done & hit_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(csi_pkg::PIPE_STAGES) done)
        else $error("result strobe missing after start");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(start, csi_pkg::PIPE_STAGES) |-> !done)
        else $error("result strobe without a matching start");
    a_hit_gated: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit raised outside a result cycle");

endmodule
